>>> src/smarms_pkg.sv
// Shared types and constants for the moving-average predictor with RMS
package smarms_pkg;

   // Field widths
   localparam int TEMP_W = 12;
   localparam int PRED_W = 15;
   localparam int ACC_W  = 16;
   localparam int RMS_W  = 16;

   // Quotient bits of the biased window average
   localparam int QUOT_W = 12;

   // Width of the square-root operand: at most 2^30
   localparam int ROOT_W = 31;

   // 25 C in 1/16 degree units
   localparam int RESET_TEMP_VAL = 400;

   // floor(x/3) == (x * RECIP_THIRD) >> 33 for any 32-bit x
   localparam logic [31:0] RECIP_THIRD = 32'hAAAA_AAAB;
   localparam int          RECIP_SHIFT = 33;

   typedef logic signed [TEMP_W-1:0] temp_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
      logic signed [ACC_W-1:0] z;
   } accel_type;

endpackage

>>> src/smarms_window.sv
// Ring window of used temperatures: registered read, then write-back of the new sample
module smarms_window #(
   parameter  int WINDOW  = 8,
   localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1,
   localparam int TOTAL_W = smarms_pkg::TEMP_W + $clog2(WINDOW)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      temp_valid,
   input  smarms_pkg::temp_type      temperature,
   output smarms_pkg::temp_type      used,
   output logic signed [TOTAL_W-1:0] total,
   output logic                      done
);

   localparam smarms_pkg::temp_type RESET_TEMP =
      smarms_pkg::TEMP_W'(smarms_pkg::RESET_TEMP_VAL);
   localparam logic signed [TOTAL_W-1:0] RESET_TOTAL =
      TOTAL_W'(smarms_pkg::RESET_TEMP_VAL * WINDOW);

   smarms_pkg::temp_type      win_mem_ff [WINDOW];
   smarms_pkg::temp_type      rd_data_ff;
   logic [WINDOW-1:0]         valid_ff;
   logic                      old_valid_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [SLOT_W-1:0]         slot_in;
   logic signed [TOTAL_W-1:0] total_ff;
   logic signed [TOTAL_W-1:0] total_in;
   smarms_pkg::temp_type      last_good_ff;
   smarms_pkg::temp_type      used_ff;
   smarms_pkg::temp_type      used_in;
   smarms_pkg::temp_type      old_val;
   logic                      rmw_ff;
   logic                      done_ff;

   // Failed read falls back to the last good sample
   assign used_in = temp_valid ? temperature : last_good_ff;

   // Entries never written read as 25 C
   assign old_val  = old_valid_ff ? rd_data_ff : RESET_TEMP;
   assign total_in = total_ff - TOTAL_W'(old_val) + TOTAL_W'(used_ff);
   assign slot_in  = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;

   // Control and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         valid_ff     <= '0;
         total_ff     <= RESET_TOTAL;
         last_good_ff <= RESET_TEMP;
         rmw_ff       <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         rmw_ff  <= start;
         done_ff <= rmw_ff;
         if (start) begin
            last_good_ff <= used_in;
         end
         if (rmw_ff) begin
            valid_ff[slot_ff] <= 1'b1;
            total_ff          <= total_in;
            slot_ff           <= slot_in;
         end
      end
   end

   // Sample capture
   always_ff @(posedge clock) begin
      if (start) begin
         used_ff      <= used_in;
         old_valid_ff <= valid_ff[slot_ff];
      end
   end

   // Window memory: read on start, write back the next cycle
   always_ff @(posedge clock) begin
      if (start) begin
         rd_data_ff <= win_mem_ff[slot_ff];
      end
      if (rmw_ff) begin
         win_mem_ff[slot_ff] <= used_ff;
      end
   end

   assign used  = used_ff;
   assign total = total_ff;
   assign done  = done_ff;

   // Write-back is a single cycle and is followed by the done pulse
   a_rmw_done: assert property (@(posedge clock) disable iff (reset)
      rmw_ff |=> done_ff && !rmw_ff)
      else $error("window write-back not followed by done");

endmodule

>>> src/smarms_avgdiv.sv
// Window average: floor of the biased total over WINDOW by reciprocal multiplication
module smarms_avgdiv #(
   parameter  int WINDOW  = 8,
   localparam int TOTAL_W = smarms_pkg::TEMP_W + $clog2(WINDOW)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [TOTAL_W-1:0] total,
   output smarms_pkg::temp_type      avg,
   output logic                      done
);

   localparam int QW      = smarms_pkg::QUOT_W;
   // Reciprocal scaled by 2^SHIFT and rounded up: exact for any dividend below 2^TOTAL_W
   localparam int SHIFT   = TOTAL_W + $clog2(WINDOW);
   localparam int RECIP_W = TOTAL_W + 2;
   localparam int PROD_W  = TOTAL_W + RECIP_W;
   localparam longint RECIP_VAL =
      ((longint'(1) << SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   // Bias of 2048*WINDOW makes the dividend non-negative; the floor then
   // comes out of a plain unsigned quotient
   localparam logic [TOTAL_W-1:0] BIAS = TOTAL_W'(2048 * WINDOW);

   logic [TOTAL_W-1:0] biased;
   logic [PROD_W-1:0]  product;
   logic [QW-1:0]      quot_ff;
   logic               done_ff;

   assign biased  = $unsigned(total) + BIAS;
   assign product = PROD_W'(biased) * PROD_W'(RECIP);

   // Completion flag, set in the cycle after start
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   // Quotient register
   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= QW'(product >> SHIFT);
      end
   end

   // Removing the bias of 2048 flips the top quotient bit
   assign avg  = {~quot_ff[QW-1], quot_ff[QW-2:0]};
   assign done = done_ff;

   // Every start is flagged as done on the next cycle
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      start |=> done_ff)
      else $error("average not flagged one cycle after start");

endmodule

>>> src/smarms_rms.sv
// Acceleration RMS: squares, sum, divide by three, then a 16-step square root
module smarms_rms (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  smarms_pkg::accel_type             accel,
   output logic [smarms_pkg::RMS_W-1:0]      rms,
   output logic                              done
);

   localparam int RW = smarms_pkg::ROOT_W;

   localparam logic [2:0] R_IDLE   = 3'd0;
   localparam logic [2:0] R_SQUARE = 3'd1;
   localparam logic [2:0] R_SUM    = 3'd2;
   localparam logic [2:0] R_SCALE  = 3'd3;
   localparam logic [2:0] R_ROOT   = 3'd4;

   logic [2:0]            state_ff;
   logic [3:0]            cnt_ff;
   logic                  done_ff;
   smarms_pkg::accel_type axes_ff;
   logic signed [31:0]    sq_x;
   logic signed [31:0]    sq_y;
   logic signed [31:0]    sq_z;
   logic [31:0]           sqx_ff;
   logic [31:0]           sqy_ff;
   logic [31:0]           sqz_ff;
   logic [31:0]           sum_ff;
   logic [63:0]           scaled;
   logic [RW-1:0]         x_ff;
   logic [RW-1:0]         res_ff;
   logic [RW-1:0]         bit_ff;
   logic [RW:0]           trial;
   logic                  take;

   assign sq_x   = axes_ff.x * axes_ff.x;
   assign sq_y   = axes_ff.y * axes_ff.y;
   assign sq_z   = axes_ff.z * axes_ff.z;
   assign scaled = sum_ff * smarms_pkg::RECIP_THIRD;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign take  = {1'b0, x_ff} >= trial;

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            R_IDLE: begin
               if (start) begin
                  state_ff <= R_SQUARE;
               end
            end
            R_SQUARE: state_ff <= R_SUM;
            R_SUM:    state_ff <= R_SCALE;
            R_SCALE: begin
               state_ff <= R_ROOT;
               cnt_ff   <= 4'd15;
            end
            R_ROOT: begin
               if (cnt_ff == '0) begin
                  state_ff <= R_IDLE;
                  done_ff  <= 1'b1;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            default: state_ff <= R_IDLE;
         endcase
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         axes_ff <= accel;
      end
      case (state_ff)
         R_SQUARE: begin
            sqx_ff <= $unsigned(sq_x);
            sqy_ff <= $unsigned(sq_y);
            sqz_ff <= $unsigned(sq_z);
         end
         R_SUM: sum_ff <= sqx_ff + sqy_ff + sqz_ff;
         R_SCALE: begin
            x_ff   <= scaled[smarms_pkg::RECIP_SHIFT +: RW];
            res_ff <= '0;
            bit_ff <= RW'(1) << (RW - 1);
         end
         R_ROOT: begin
            if (take) begin
               x_ff   <= x_ff - trial[RW-1:0];
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         default: ;
      endcase
   end

   assign rms  = res_ff[smarms_pkg::RMS_W-1:0];
   assign done = done_ff;

endmodule

>>> src/sensor_moving_average_predict_rms.sv
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall temp_valid, temperature, accel_x/y/z
// rsp      out        rsp_valid/rsp_stall used_temperature, predicted_temperature, accel_rms
//
// One transaction at a time; the time from acceptance to result is set by the
// 16-step square root after squaring, summing and scaling; the window read,
// write-back and reciprocal multiply for the average finish inside that span.
// Reset: per-entry valid bits make every window entry read as 25 C, so requests
// are taken from the first cycle after reset. A result waiting in the output
// register does not stall the next request; a new result waits for it to empty.
module sensor_moving_average_predict_rms #(
   parameter int WINDOW = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_temp_valid,
   input  logic signed [smarms_pkg::TEMP_W-1:0]      req_temperature,
   input  logic signed [smarms_pkg::ACC_W-1:0]       req_accel_x,
   input  logic signed [smarms_pkg::ACC_W-1:0]       req_accel_y,
   input  logic signed [smarms_pkg::ACC_W-1:0]       req_accel_z,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [smarms_pkg::TEMP_W-1:0]      rsp_used_temperature,
   output logic signed [smarms_pkg::PRED_W-1:0]      rsp_predicted_temperature,
   output logic        [smarms_pkg::RMS_W-1:0]       rsp_accel_rms
);

   localparam int TOTAL_W = smarms_pkg::TEMP_W + $clog2(WINDOW);
   localparam int PW      = smarms_pkg::PRED_W;

   localparam logic T_IDLE = 1'b0;
   localparam logic T_BUSY = 1'b1;

   logic                               state_ff;
   logic                               div_seen_ff;
   logic                               rms_seen_ff;
   logic                               rsp_valid_ff;
   smarms_pkg::temp_type               used_out_ff;
   logic signed [PW-1:0]               pred_ff;
   logic [smarms_pkg::RMS_W-1:0]       rms_out_ff;
   logic                               req_accept;
   logic                               out_free;
   logic                               finish;
   smarms_pkg::accel_type              accel;
   smarms_pkg::temp_type               win_used;
   logic signed [TOTAL_W-1:0]          win_total;
   logic                               win_done;
   smarms_pkg::temp_type               div_avg;
   logic                               div_done;
   logic [smarms_pkg::RMS_W-1:0]       rms_val;
   logic                               rms_done;
   logic signed [PW-1:0]               used_ext;
   logic signed [PW-1:0]               avg_ext;
   logic signed [PW-1:0]               pred_in;

   assign req_stall  = (state_ff == T_BUSY);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign finish     = (state_ff == T_BUSY) && div_seen_ff && rms_seen_ff && out_free;

   assign accel = '{x: req_accel_x, y: req_accel_y, z: req_accel_z};

   smarms_window #(.WINDOW(WINDOW)) u_window (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .temp_valid  (req_temp_valid),
      .temperature (req_temperature),
      .used        (win_used),
      .total       (win_total),
      .done        (win_done)
   );

   smarms_avgdiv #(.WINDOW(WINDOW)) u_avgdiv (
      .clock (clock),
      .reset (reset),
      .start (win_done),
      .total (win_total),
      .avg   (div_avg),
      .done  (div_done)
   );

   smarms_rms u_rms (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .accel (accel),
      .rms   (rms_val),
      .done  (rms_done)
   );

   // Prediction: 3*used - 2*avg
   assign used_ext = PW'(win_used);
   assign avg_ext  = PW'(div_avg);
   assign pred_in  = (used_ext <<< 1) + used_ext - (avg_ext <<< 1);

   // Transaction control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         div_seen_ff  <= 1'b0;
         rms_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff    <= T_BUSY;
            div_seen_ff <= 1'b0;
            rms_seen_ff <= 1'b0;
         end else begin
            if (div_done) begin
               div_seen_ff <= 1'b1;
            end
            if (rms_done) begin
               rms_seen_ff <= 1'b1;
            end
            if (finish) begin
               state_ff <= T_IDLE;
            end
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (finish) begin
         used_out_ff <= win_used;
         pred_ff     <= pred_in;
         rms_out_ff  <= rms_val;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_used_temperature      = used_out_ff;
   assign rsp_predicted_temperature = pred_ff;
   assign rsp_accel_rms             = rms_out_ff;

   // A new transaction starts with both completion flags cleared
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == T_BUSY && !div_seen_ff && !rms_seen_ff)
      else $error("accepted transaction did not start cleanly");

   // Finishing loads the result register and frees the input side
   a_finish_out: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff && state_ff == T_IDLE)
      else $error("finished transaction not presented");

   // No result is presented before the average of the current transaction is ready
   a_no_stale: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_BUSY && !div_seen_ff |=> !finish || div_seen_ff)
      else $error("result taken before the average was ready");

endmodule

>>> tb/sensor_moving_average_predict_rms_test.sv
module sensor_moving_average_predict_rms_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_LEN = 8;

   // Expected outcome of one sample transaction
   typedef struct {
      smarms_pkg::temp_type                 used;
      logic signed [smarms_pkg::PRED_W-1:0] pred;
      logic        [smarms_pkg::RMS_W-1:0]  rms;
   } forecast_type;

   // Tracks the temperature window and the forecasts still owed by the block
   class forecast_tracker_type;
      smarms_pkg::temp_type window [WINDOW_LEN];
      int                   slot;
      int                   total;
      smarms_pkg::temp_type last_good;
      forecast_type         forecasts_due [$];
      int                   failures;

      function new();
         foreach (window[i]) window[i] = smarms_pkg::temp_type'(smarms_pkg::RESET_TEMP_VAL);
         slot      = 0;
         total     = smarms_pkg::RESET_TEMP_VAL * WINDOW_LEN;
         last_good = smarms_pkg::temp_type'(smarms_pkg::RESET_TEMP_VAL);
         failures  = 0;
      endfunction

      // digit-by-digit floor square root, 16 result bits
      function int unsigned floor_root(longint unsigned v);
         int unsigned r;
         r = 0;
         for (int b = 15; b >= 0; b--) begin
            longint unsigned c;
            c = longint'(r) | (64'd1 << b);
            if (c * c <= v) r = int'(c);
         end
         return r;
      endfunction

      function void log_sample(logic tv, smarms_pkg::temp_type t,
                               logic signed [smarms_pkg::ACC_W-1:0] ax,
                               logic signed [smarms_pkg::ACC_W-1:0] ay,
                               logic signed [smarms_pkg::ACC_W-1:0] az);
         forecast_type    f;
         int              avg;
         longint          energy;
         if (tv) last_good = t;
         total        = total - int'(window[slot]) + int'(last_good);
         window[slot] = last_good;
         slot         = (slot == WINDOW_LEN - 1) ? 0 : slot + 1;
         // window length is a power of two: arithmetic shift floors
         avg    = total >>> $clog2(WINDOW_LEN);
         f.used = last_good;
         f.pred = smarms_pkg::PRED_W'(3 * int'(last_good) - 2 * avg);
         energy = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
         f.rms  = smarms_pkg::RMS_W'(floor_root(longint'(energy / 3)));
         forecasts_due.push_back(f);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void verify_forecast(smarms_pkg::temp_type used,
                                    logic signed [smarms_pkg::PRED_W-1:0] pred,
                                    logic [smarms_pkg::RMS_W-1:0] rms);
         forecast_type f;
         if (forecasts_due.size() == 0) begin
            $error("result with nothing outstanding: used %0d pred %0d rms %0d",
                   used, pred, rms);
            failures++;
            return;
         end
         f = forecasts_due.pop_front();
         compare_field("used_temperature", int'(f.used), int'(used));
         compare_field("predicted_temperature", int'(f.pred), int'(pred));
         compare_field("accel_rms", int'(f.rms), int'(rms));
      endfunction

      function int pending();
         return forecasts_due.size();
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic                                 req_temp_valid;
   logic signed [smarms_pkg::TEMP_W-1:0] req_temperature;
   logic signed [smarms_pkg::ACC_W-1:0]  req_accel_x;
   logic signed [smarms_pkg::ACC_W-1:0]  req_accel_y;
   logic signed [smarms_pkg::ACC_W-1:0]  req_accel_z;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic signed [smarms_pkg::TEMP_W-1:0] rsp_used_temperature;
   logic signed [smarms_pkg::PRED_W-1:0] rsp_predicted_temperature;
   logic        [smarms_pkg::RMS_W-1:0]  rsp_accel_rms;

   forecast_tracker_type book;
   bit                   steady;   // no random gaps or stalls on either side while set

   sensor_moving_average_predict_rms #(.WINDOW(WINDOW_LEN)) dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_temp_valid            (req_temp_valid),
      .req_temperature           (req_temperature),
      .req_accel_x               (req_accel_x),
      .req_accel_y               (req_accel_y),
      .req_accel_z               (req_accel_z),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_used_temperature      (rsp_used_temperature),
      .rsp_predicted_temperature (rsp_predicted_temperature),
      .rsp_accel_rms             (rsp_accel_rms)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // present one transaction, wait for it to be taken, then idle for a random gap, possibly none
   task automatic send_sample(input logic tv, input int t, input int ax, input int ay,
                              input int az);
      int gap;
      @(negedge clock);
      req_valid       = 1'b1;
      req_temp_valid  = tv;
      req_temperature = smarms_pkg::TEMP_W'(t);
      req_accel_x     = smarms_pkg::ACC_W'(ax);
      req_accel_y     = smarms_pkg::ACC_W'(ay);
      req_accel_z     = smarms_pkg::ACC_W'(az);
      do @(posedge clock); while (req_stall);
      book.log_sample(req_temp_valid, req_temperature, req_accel_x, req_accel_y,
                      req_accel_z);
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // hold off until every outstanding result has come back
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (book.pending() != 0) @(posedge clock);
   endtask

   // result side back-pressure
   initial begin
      int run;
      rsp_stall = 1'b0;
      run       = 0;
      forever begin
         @(negedge clock);
         if (steady) begin
            rsp_stall = 1'b0;
            run       = 0;
         end else if (run > 0) begin
            run--;
         end else begin
            rsp_stall = ($urandom_range(0, 2) == 0);
            run       = pick_gap();
         end
      end
   end

   // result monitor
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            book.verify_forecast(rsp_used_temperature, rsp_predicted_temperature,
                                 rsp_accel_rms);
      end
   end

   // stimulus
   initial begin
      int r;
      int walk;
      int t;
      int ax;
      int ay;
      int az;
      int extremes_t [4];
      int extremes_a [3];
      extremes_t = '{-2048, 2047, 0, -1};
      extremes_a = '{-32768, 32767, 0};
      book            = new();
      steady          = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_temp_valid  = 1'b0;
      req_temperature = '0;
      req_accel_x     = '0;
      req_accel_y     = '0;
      req_accel_z     = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, failed reads, negative averages, window wrap
      send_sample(1'b1, 400, 0, 0, 0);
      send_sample(1'b1, 2047, 32767, 32767, 32767);
      send_sample(1'b1, -2048, -32768, -32768, -32768);
      send_sample(1'b0, 1234, 0, 0, 0);
      send_sample(1'b0, 2047, -32768, 32767, 0);
      for (int i = 0; i < 8; i++)
         send_sample(1'b1, -2048, i + 1, -i * 3, 32767 - i);
      send_sample(1'b0, -5, 1, 1, 1);
      for (int i = 0; i < 8; i++)
         send_sample(1'b1, -1, -i, i * 100, 2);
      send_sample(1'b1, 0, 1, 0, 0);
      send_sample(1'b1, 1, 2, 2, 2);
      drain();

      // random: mostly slowly drifting readings, plus noise, failed reads and field extremes
      walk = 400;
      for (int phase = 0; phase < 17; phase++) begin
         steady = (phase % 4 == 1);
         for (int n = 0; n < 50; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               walk = walk + $urandom_range(0, 64) - 32;
               if (walk > 2047) walk = 2047;
               if (walk < -2048) walk = -2048;
               ax = $urandom_range(0, 4095) - 2048;
               ay = $urandom_range(0, 4095) - 2048;
               az = $urandom_range(0, 4095) - 2048;
               send_sample(1'b1, walk, ax, ay, az);
            end else if (r < 85) begin
               t  = $urandom_range(0, 4095) - 2048;
               ax = $urandom_range(0, 65535) - 32768;
               ay = $urandom_range(0, 65535) - 32768;
               az = $urandom_range(0, 65535) - 32768;
               send_sample(1'b1, t, ax, ay, az);
            end else if (r < 95) begin
               t  = $urandom_range(0, 4095) - 2048;
               ax = $urandom_range(0, 65535) - 32768;
               ay = $urandom_range(0, 65535) - 32768;
               az = $urandom_range(0, 65535) - 32768;
               send_sample(1'b0, t, ax, ay, az);
            end else begin
               send_sample(1'($urandom_range(0, 1)), extremes_t[$urandom_range(0, 3)],
                           extremes_a[$urandom_range(0, 2)],
                           extremes_a[$urandom_range(0, 2)],
                           extremes_a[$urandom_range(0, 2)]);
            end
         end
         if (phase % 5 == 4) drain();
      end
      steady = 1'b0;

      // wind down: everything back, then a margin for stray results
      drain();
      repeat (40) @(posedge clock);
      if (book.failures == 0 && book.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

>>> sensor_moving_average_predict_rms.f
src/smarms_pkg.sv
src/smarms_window.sv
src/smarms_avgdiv.sv
src/smarms_rms.sv
src/sensor_moving_average_predict_rms.sv
tb/sensor_moving_average_predict_rms_test.sv
